// ===== hw/rtl/rpa_pkg.sv =====
// shared constants, codes and types of the refcounted page allocator
// no dependencies; imported by every module of the block but rpa_ram
package rpa_pkg;

  localparam int MaxPages        = 1024;
  localparam int PageW           = 10;
  localparam int DepthW          = 11;
  localparam int KindW           = 3;
  localparam int PageIdW         = 11;
  localparam int CountW          = 7;
  localparam int HashW           = 64;
  localparam int MaxBatchDefault = 64;
  localparam int RefBitsDefault  = 16;

  // operation codes
  typedef enum logic [KindW-1:0] {
    KindAlloc   = 3'd0,
    KindFree    = 3'd1,
    KindAddRef  = 3'd2,
    KindSetHash = 3'd3,
    KindLookup  = 3'd4,
    KindDefrag  = 3'd5
  } kind_e;

  // result status codes
  typedef enum logic [1:0] {
    StatOk       = 2'd0,
    StatNoSpace  = 2'd1,
    StatNotFound = 2'd2,
    StatIgnored  = 2'd3
  } status_e;

  // one result word from the controller
  typedef struct packed {
    status_e            status;
    logic [PageW-1:0]   page;
    logic               last;
    logic [DepthW-1:0]  free_pages;
  } res_t;

endpackage

// ===== hw/rtl/rpa_ram.sv =====
// simple dual-port synchronous ram, one write and one registered read port
// uses no package
module rpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== hw/rtl/rpa_ctrl.sv =====
// operation sequencer: read-modify-write of page and stack memories, sweeps
// depends on rpa_pkg; drives two rpa_ram instances held by the top level
module rpa_ctrl import rpa_pkg::*; #(
  parameter int REF_BITS  = RefBitsDefault,
  parameter int MAX_BATCH = MaxBatchDefault,
  parameter int PG_W      = 2 + REF_BITS + HashW
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [KindW-1:0]   in_kind_i,
  input  logic [PageIdW-1:0] in_page_id_i,
  input  logic [CountW-1:0]  in_count_i,
  input  logic [HashW-1:0]   in_hash_i,
  output logic               res_valid_o,
  output res_t               res_o,
  input  logic               res_ready_i,
  output logic               pg_we_o,
  output logic [PageW-1:0]   pg_waddr_o,
  output logic [PG_W-1:0]    pg_wdata_o,
  output logic [PageW-1:0]   pg_raddr_o,
  input  logic [PG_W-1:0]    pg_rdata_i,
  output logic               st_we_o,
  output logic [PageW-1:0]   st_waddr_o,
  output logic [PageW-1:0]   st_wdata_o,
  output logic [PageW-1:0]   st_raddr_o,
  input  logic [PageW-1:0]   st_rdata_i
);

  localparam logic [REF_BITS-1:0] RefMax  = '1;
  localparam logic [REF_BITS-1:0] RefOne  = REF_BITS'(1);
  localparam logic [PageW-1:0]    LastPg  = PageW'(MaxPages - 1);

  typedef enum logic [3:0] {
    StClear, StIdle, StDispatch, StAllocRd, StAllocWr, StPageOp,
    StSetSweep, StSetFin, StLook, StDefrag, StEmit
  } state_e;

  function automatic logic [PG_W-1:0] pg_pack(input logic a, input logic x,
      input logic [REF_BITS-1:0] r, input logic [HashW-1:0] h);
    pg_pack = {a, x, r, h};
  endfunction

  state_e               state_q, state_d;
  logic [DepthW-1:0]    depth_q, depth_d;
  logic [DepthW-1:0]    dcnt_q, dcnt_d;
  logic [CountW-1:0]    i_q, i_d;
  logic [PageW-1:0]     clr_q, clr_d;
  logic                 sw_issue_q, sw_issue_d;
  logic                 sw_ev_q, sw_ev_d;
  logic [KindW-1:0]     kind_q, kind_d;
  logic [PageIdW-1:0]   pid_q, pid_d;
  logic [CountW-1:0]    cnt_q, cnt_d;
  logic [HashW-1:0]     key_q, key_d;
  logic [REF_BITS-1:0]  refs_q, refs_d;
  logic [PageW-1:0]     sw_addr_q, sw_addr_d;
  logic [PageW-1:0]     ev_addr_q, ev_addr_d;
  res_t                 res_q, res_d;

  // fields of the page word just read
  logic                r_alloc, r_idx;
  logic [REF_BITS-1:0] r_refs, r_inc, r_dec;
  logic [HashW-1:0]    r_hash;
  logic                r_hit;
  logic [PageW-1:0]    sw_end, pid_pg;
  logic                sw_last;

  assign r_alloc = pg_rdata_i[PG_W-1];
  assign r_idx   = pg_rdata_i[PG_W-2];
  assign r_refs  = pg_rdata_i[HashW +: REF_BITS];
  assign r_hash  = pg_rdata_i[HashW-1:0];
  assign r_inc   = (r_refs == RefMax) ? r_refs : r_refs + RefOne;
  assign r_dec   = (r_refs != '0) ? r_refs - RefOne : r_refs;
  assign r_hit   = r_idx && (r_hash == key_q);
  assign pid_pg  = pid_q[PageW-1:0];
  assign sw_end  = (state_q == StDefrag) ? '0 : LastPg;
  assign sw_last = sw_ev_q && (ev_addr_q == sw_end);

  assign in_ready_o  = (state_q == StIdle);
  assign res_valid_o = (state_q == StEmit);
  always_comb begin
    res_o            = res_q;
    res_o.free_pages = depth_q;
  end

  // next-state and memory access logic
  always_comb begin
    state_d    = state_q;
    depth_d    = depth_q;
    dcnt_d     = dcnt_q;
    i_d        = i_q;
    clr_d      = clr_q;
    sw_issue_d = sw_issue_q;
    sw_ev_d    = sw_ev_q;
    kind_d     = kind_q;
    pid_d      = pid_q;
    cnt_d      = cnt_q;
    key_d      = key_q;
    refs_d     = refs_q;
    sw_addr_d  = sw_addr_q;
    ev_addr_d  = ev_addr_q;
    res_d      = res_q;
    pg_we_o    = 1'b0;
    pg_waddr_o = '0;
    pg_wdata_o = '0;
    pg_raddr_o = sw_addr_q;
    st_we_o    = 1'b0;
    st_waddr_o = '0;
    st_wdata_o = '0;
    st_raddr_o = '0;

    // shared sweep address pipeline: issue one read, evaluate the previous
    if (state_q == StSetSweep || state_q == StLook || state_q == StDefrag) begin
      if (sw_issue_q) begin
        ev_addr_d = sw_addr_q;
        sw_ev_d   = 1'b1;
        if (sw_addr_q == sw_end) begin
          sw_issue_d = 1'b0;
        end else if (state_q == StDefrag) begin
          sw_addr_d = sw_addr_q - 1'b1;
        end else begin
          sw_addr_d = sw_addr_q + 1'b1;
        end
      end else begin
        sw_ev_d = 1'b0;
      end
    end

    unique case (state_q)
      StClear: begin
        pg_we_o    = 1'b1;
        pg_waddr_o = clr_q;
        st_we_o    = 1'b1;
        st_waddr_o = clr_q;
        st_wdata_o = ~clr_q;
        clr_d      = clr_q + 1'b1;
        if (clr_q == LastPg) state_d = StIdle;
      end
      StIdle: begin
        if (in_valid_i) begin
          kind_d  = in_kind_i;
          pid_d   = in_page_id_i;
          cnt_d   = in_count_i;
          key_d   = in_hash_i;
          state_d = StDispatch;
        end
      end
      StDispatch: begin
        state_d   = StEmit;
        res_d     = '0;
        res_d.last = 1'b1;
        unique case (kind_q)
          KindAlloc: begin
            if (cnt_q == '0) begin
              res_d.status = StatOk;
            end else if (cnt_q > CountW'(MAX_BATCH)) begin
              res_d.status = StatIgnored;
            end else if (depth_q < DepthW'(cnt_q)) begin
              res_d.status = StatNoSpace;
            end else begin
              i_d     = '0;
              state_d = StAllocRd;
            end
          end
          KindFree, KindAddRef, KindSetHash: begin
            if (pid_q[PageIdW-1]) begin
              res_d.status = StatIgnored;
            end else begin
              pg_raddr_o = pid_pg;
              state_d    = StPageOp;
            end
          end
          KindLookup: begin
            if (key_q == '0) begin
              res_d.status = StatNotFound;
            end else begin
              sw_addr_d  = '0;
              sw_issue_d = 1'b1;
              sw_ev_d    = 1'b0;
              state_d    = StLook;
            end
          end
          KindDefrag: begin
            sw_addr_d  = LastPg;
            sw_issue_d = 1'b1;
            sw_ev_d    = 1'b0;
            dcnt_d     = '0;
            state_d    = StDefrag;
          end
          default: res_d.status = StatIgnored;
        endcase
      end
      StAllocRd: begin
        depth_d    = depth_q - 1'b1;
        st_raddr_o = depth_d[PageW-1:0];
        state_d    = StAllocWr;
      end
      StAllocWr: begin
        pg_we_o      = 1'b1;
        pg_waddr_o   = st_rdata_i;
        pg_wdata_o   = pg_pack(1'b1, 1'b0, RefOne, '0);
        i_d          = i_q + 1'b1;
        res_d.status = StatOk;
        res_d.page   = st_rdata_i;
        res_d.last   = (i_d == cnt_q);
        state_d      = StEmit;
      end
      StPageOp: begin
        state_d = StEmit;
        if (!r_alloc) begin
          res_d.status = StatIgnored;
        end else begin
          res_d.status = StatOk;
          pg_we_o      = 1'b1;
          pg_waddr_o   = pid_pg;
          unique case (kind_q)
            KindFree: begin
              if (r_dec == '0) begin
                pg_wdata_o = '0;
                if (depth_q < DepthW'(MaxPages)) begin
                  st_we_o    = 1'b1;
                  st_waddr_o = depth_q[PageW-1:0];
                  st_wdata_o = pid_pg;
                  depth_d    = depth_q + 1'b1;
                end
              end else begin
                pg_wdata_o = pg_pack(1'b1, r_idx, r_dec, r_hash);
              end
            end
            KindAddRef: pg_wdata_o = pg_pack(1'b1, r_idx, r_inc, r_hash);
            default: begin
              // set prefix hash: drop own flag, nonzero: clear other holders
              pg_wdata_o = pg_pack(1'b1, 1'b0, r_refs, key_q);
              refs_d     = r_refs;
              if (key_q != '0) begin
                sw_addr_d  = '0;
                sw_issue_d = 1'b1;
                sw_ev_d    = 1'b0;
                state_d    = StSetSweep;
              end
            end
          endcase
        end
      end
      StSetSweep: begin
        if (sw_ev_q && (ev_addr_q != pid_pg) && r_hit) begin
          pg_we_o    = 1'b1;
          pg_waddr_o = ev_addr_q;
          pg_wdata_o = pg_pack(r_alloc, 1'b0, r_refs, r_hash);
        end
        if (sw_last) state_d = StSetFin;
      end
      StSetFin: begin
        pg_we_o      = 1'b1;
        pg_waddr_o   = pid_pg;
        pg_wdata_o   = pg_pack(1'b1, 1'b1, refs_q, key_q);
        res_d.status = StatOk;
        state_d      = StEmit;
      end
      StLook: begin
        if (sw_ev_q && r_hit) begin
          pg_we_o    = 1'b1;
          pg_waddr_o = ev_addr_q;
          state_d    = StEmit;
          if (!r_alloc) begin
            // stale flag on a released page
            pg_wdata_o   = pg_pack(1'b0, 1'b0, r_refs, r_hash);
            res_d.status = StatNotFound;
          end else begin
            pg_wdata_o   = pg_pack(1'b1, 1'b1, r_inc, r_hash);
            res_d.status = StatOk;
            res_d.page   = ev_addr_q;
          end
        end else if (sw_last) begin
          res_d.status = StatNotFound;
          state_d      = StEmit;
        end
      end
      StDefrag: begin
        if (sw_ev_q && !r_alloc) begin
          st_we_o    = 1'b1;
          st_waddr_o = dcnt_q[PageW-1:0];
          st_wdata_o = ev_addr_q;
          dcnt_d     = dcnt_q + 1'b1;
        end
        if (sw_last) begin
          depth_d      = dcnt_d;
          res_d.status = StatOk;
          state_d      = StEmit;
        end
      end
      StEmit: begin
        if (res_ready_i) begin
          state_d = res_q.last ? StIdle : StAllocRd;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StClear;
      depth_q    <= DepthW'(MaxPages);
      dcnt_q     <= '0;
      i_q        <= '0;
      clr_q      <= '0;
      sw_issue_q <= 1'b0;
      sw_ev_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      depth_q    <= depth_d;
      dcnt_q     <= dcnt_d;
      i_q        <= i_d;
      clr_q      <= clr_d;
      sw_issue_q <= sw_issue_d;
      sw_ev_q    <= sw_ev_d;
    end
  end

  // operand and result payload
  always_ff @(posedge clk_i) begin
    kind_q    <= kind_d;
    pid_q     <= pid_d;
    cnt_q     <= cnt_d;
    key_q     <= key_d;
    refs_q    <= refs_d;
    sw_addr_q <= sw_addr_d;
    ev_addr_q <= ev_addr_d;
    res_q     <= res_d;
  end

endmodule

// ===== hw/rtl/refcounted_page_allocator.sv =====
// top level of the refcounted page allocator: stream ports, output register
// depends on rpa_pkg, rpa_ram and rpa_ctrl
//
// Usage: one operation word enters on the s_axis channel, the operation kind on
// s_axis_tuser, and each operation returns one or more result words on m_axis;
// m_axis_tlast marks the final result of an operation. Operations are handled
// one at a time.
// Work per operation:
//   free, add_ref, hash write with zero hash: one read-modify-write of the entry
//   rejected requests: a result word and no write
//   allocate: one free stack read and one page write per granted page
//   hash write with nonzero hash: walk of the page memory
//   prefix lookup: walk of the page memory, ends at the first indexed match
//   defrag: walk of the page memory, one entry per cycle
// A walk goes through the single read port of the page memory, one entry per cycle.
// After reset a clearing pass over every entry initializes the page memory
// and the free stack; s_axis_tready stays low until it ends.
// A result word waits in an output register while m_axis_tready is low;
// the sequencer holds further results until that register drains.
module refcounted_page_allocator import rpa_pkg::*; #(
  parameter int REF_BITS  = RefBitsDefault,
  parameter int MAX_BATCH = MaxBatchDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // page_id[10:0], count[17:11], hash_key[81:18], zero fill
  input  logic [87:0] s_axis_tdata,
  // kind[2:0]
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status[1:0], result_page[11:2], free_pages[22:12], used_pages[33:23], zero fill
  output logic [39:0] m_axis_tdata,
  output logic        m_axis_tlast
);

  localparam int PgW = 2 + REF_BITS + HashW;

  logic             pg_we;
  logic [PageW-1:0] pg_waddr, pg_raddr;
  logic [PgW-1:0]   pg_wdata, pg_rdata;
  logic             st_we;
  logic [PageW-1:0] st_waddr, st_wdata, st_raddr, st_rdata;
  logic             res_valid, res_ready;
  res_t             res;
  logic             out_valid_q;
  res_t             out_q;
  logic [DepthW-1:0] used_pages;

  // page entries: allocated, indexed, refs, hash
  rpa_ram #(.WIDTH(PgW), .DEPTH(MaxPages)) u_page_ram (
    .clk_i   (clk_i),
    .we_i    (pg_we),
    .waddr_i (pg_waddr),
    .wdata_i (pg_wdata),
    .raddr_i (pg_raddr),
    .rdata_o (pg_rdata)
  );

  // free stack
  rpa_ram #(.WIDTH(PageW), .DEPTH(MaxPages)) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (st_wdata),
    .raddr_i (st_raddr),
    .rdata_o (st_rdata)
  );

  rpa_ctrl #(.REF_BITS(REF_BITS), .MAX_BATCH(MAX_BATCH), .PG_W(PgW)) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_kind_i    (s_axis_tuser),
    .in_page_id_i (s_axis_tdata[10:0]),
    .in_count_i   (s_axis_tdata[17:11]),
    .in_hash_i    (s_axis_tdata[81:18]),
    .res_valid_o  (res_valid),
    .res_o        (res),
    .res_ready_i  (res_ready),
    .pg_we_o      (pg_we),
    .pg_waddr_o   (pg_waddr),
    .pg_wdata_o   (pg_wdata),
    .pg_raddr_o   (pg_raddr),
    .pg_rdata_i   (pg_rdata),
    .st_we_o      (st_we),
    .st_waddr_o   (st_waddr),
    .st_wdata_o   (st_wdata),
    .st_raddr_o   (st_raddr),
    .st_rdata_i   (st_rdata)
  );

  // output register
  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  // result word
  assign used_pages    = DepthW'(MaxPages) - out_q.free_pages;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_q.last;
  assign m_axis_tdata  = {6'b0, used_pages, out_q.free_pages, out_q.page, out_q.status};

endmodule

// ===== verif/rpa_checker.sv =====
// checker for the refcounted page allocator: watches both stream channels,
// predicts result words from accepted operation words and compares them
// depends on rpa_pkg
`timescale 1ns / 100ps

module rpa_checker import rpa_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [87:0] s_axis_tdata,
  input  logic [2:0]  s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [39:0] m_axis_tdata,
  input  logic        m_axis_tlast,
  output int          fail_count_o,
  output int          pending_o
);

  localparam int RefMax = (1 << RefBitsDefault) - 1;

  typedef struct packed {
    logic [1:0]        status;
    logic [PageW-1:0]  page;
    logic              last;
    logic [DepthW-1:0] free_pages;
    logic [DepthW-1:0] used_pages;
  } exp_word_t;

  // allocator state mirror
  bit              alloc_q [MaxPages];
  int unsigned     refs_q [MaxPages];
  logic [HashW-1:0] hash_q [MaxPages];
  bit              indexed_q [MaxPages];
  int unsigned     stack_q [MaxPages];
  int unsigned     depth_q;

  exp_word_t expected_words[$];

  assign pending_o = expected_words.size();

  function automatic void push_word(logic [1:0] st, int unsigned pg, bit lst);
    exp_word_t w;
    w.status     = st;
    w.page       = pg[PageW-1:0];
    w.last       = lst;
    w.free_pages = depth_q[DepthW-1:0];
    w.used_pages = DepthW'(MaxPages - depth_q);
    expected_words = {expected_words, w};
  endfunction

  function automatic void reset_pool();
    for (int k = 0; k < MaxPages; k++) begin
      alloc_q[k] = 0; refs_q[k] = 0; hash_q[k] = '0; indexed_q[k] = 0;
      stack_q[k] = MaxPages - 1 - k;
    end
    depth_q = MaxPages;
  endfunction

  // predict the result words of one operation
  function automatic void predict_op(logic [KindW-1:0] kind, logic [87:0] d);
    logic [PageIdW-1:0] pid;
    logic [CountW-1:0]  cnt;
    logic [HashW-1:0]   hk;
    int unsigned        p;
    bit                 found;
    int unsigned        nd;
    pid   = d[10:0];
    cnt   = d[17:11];
    hk    = d[81:18];
    found = 0;
    case (kind)
      KindAlloc: begin
        if (cnt == 0) push_word(StatOk, 0, 1);
        else if (cnt > MaxBatchDefault) push_word(StatIgnored, 0, 1);
        else if (depth_q < cnt) push_word(StatNoSpace, 0, 1);
        else begin
          for (int i = 0; i < cnt; i++) begin
            depth_q--;
            p = stack_q[depth_q] % MaxPages;
            alloc_q[p] = 1; refs_q[p] = 1; hash_q[p] = '0; indexed_q[p] = 0;
            push_word(StatOk, p, i + 1 == cnt);
          end
        end
      end
      KindFree, KindAddRef, KindSetHash: begin
        if (pid >= MaxPages || !alloc_q[pid]) push_word(StatIgnored, 0, 1);
        else begin
          p = pid;
          if (kind == KindFree) begin
            if (refs_q[p] > 0) refs_q[p]--;
            if (refs_q[p] == 0) begin
              indexed_q[p] = 0; alloc_q[p] = 0; hash_q[p] = '0;
              if (depth_q < MaxPages) begin
                stack_q[depth_q] = p;
                depth_q++;
              end
            end
          end else if (kind == KindAddRef) begin
            if (refs_q[p] < RefMax) refs_q[p]++;
          end else begin
            indexed_q[p] = 0;
            hash_q[p] = hk;
            if (hk != 0) begin
              for (int q = 0; q < MaxPages; q++)
                if (indexed_q[q] && hash_q[q] == hk) indexed_q[q] = 0;
              indexed_q[p] = 1;
            end
          end
          push_word(StatOk, 0, 1);
        end
      end
      KindLookup: begin
        if (hk != 0) begin
          for (int q = 0; q < MaxPages; q++) begin
            if (indexed_q[q] && hash_q[q] == hk) begin
              if (alloc_q[q]) begin
                if (refs_q[q] < RefMax) refs_q[q]++;
                push_word(StatOk, q, 1);
                found = 1;
              end else indexed_q[q] = 0;
              break;
            end
          end
        end
        if (!found) push_word(StatNotFound, 0, 1);
      end
      KindDefrag: begin
        nd = 0;
        for (int q = MaxPages; q > 0; q--)
          if (!alloc_q[q-1]) begin
            stack_q[nd] = q - 1;
            nd++;
          end
        depth_q = nd;
        push_word(StatOk, 0, 1);
      end
      default: push_word(StatIgnored, 0, 1);
    endcase
  endfunction

  // compare one result word against the oldest expectation
  function automatic void check_word(logic [39:0] d, logic lst);
    exp_word_t e;
    if (expected_words.size() == 0) begin
      $error("result word with nothing expected: %h", d);
      fail_count_o++;
      return;
    end
    e = expected_words.pop_front();
    if (d[1:0] !== e.status) begin
      $error("status exp %0d got %0d", e.status, d[1:0]); fail_count_o++;
    end
    if (d[11:2] !== e.page) begin
      $error("result_page exp %0d got %0d", e.page, d[11:2]); fail_count_o++;
    end
    if (lst !== e.last) begin
      $error("last exp %0d got %0d", e.last, lst); fail_count_o++;
    end
    if (d[22:12] !== e.free_pages) begin
      $error("free_pages exp %0d got %0d", e.free_pages, d[22:12]); fail_count_o++;
    end
    if (d[33:23] !== e.used_pages) begin
      $error("used_pages exp %0d got %0d", e.used_pages, d[33:23]); fail_count_o++;
    end
  endfunction

  // watch both channels, mirror starts from the reset state
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      reset_pool();
      expected_words.delete();
      fail_count_o = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) predict_op(s_axis_tuser, s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) check_word(m_axis_tdata, m_axis_tlast);
    end
  end

endmodule

// ===== verif/tb_top.sv =====
// testbench top of the refcounted page allocator: clock, reset, operation
// stimulus with random idling, verdict; uses rpa_pkg, rpa_checker, the DUT
`timescale 1ns / 100ps

module tb_top import rpa_pkg::*; ();

  localparam int IdleLimit = 20000;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [87:0] s_axis_tdata;
  logic [2:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tlast;
  int          fail_count;
  int          pending;
  int          send_idle_pct;
  int          recv_idle_pct;
  int          idle_cycles = 0;
  logic [HashW-1:0] hash_pool [8];
  int unsigned live_pages [$];

  refcounted_page_allocator u_dut (.*);

  rpa_checker u_chk (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 0;
    forever #2 clk_i = ~clk_i;
  end

  // receiver stalls at random
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // watchdog on cycles without any accepted word
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // send one operation word, with a random gap before it
  task automatic send_op(logic [KindW-1:0] kind, logic [PageIdW-1:0] pid,
                         logic [CountW-1:0] cnt, logic [HashW-1:0] hk);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {6'b000000, hk, cnt, pid};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // stop sending and wait for every expected result word
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // pick a page id, mostly a live one
  function automatic logic [PageIdW-1:0] pick_page();
    int r;
    r = $urandom_range(9);
    if (r < 7 && live_pages.size() != 0)
      return PageIdW'(live_pages[$urandom_range(live_pages.size() - 1)]);
    if (r == 7) return PageIdW'($urandom_range(2047, 1024));
    return PageIdW'($urandom_range(1023));
  endfunction

  task automatic random_phase(int n);
    int r;
    logic [PageIdW-1:0] pid;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      pid = pick_page();
      if (r < 25) begin
        send_op(KindAlloc, PageIdW'($urandom),
                (r < 2) ? CountW'($urandom_range(127, 65)) : CountW'($urandom_range(8)),
                HashW'($urandom));
        for (int k = 0; k < 4; k++) live_pages = {live_pages, $urandom_range(40)};
      end else if (r < 40) send_op(KindFree, pid, CountW'($urandom), HashW'($urandom));
      else if (r < 50) send_op(KindAddRef, pid, CountW'($urandom), HashW'($urandom));
      else if (r < 65) send_op(KindSetHash, pid, CountW'($urandom),
                               ($urandom_range(5) == 0) ? 64'd0
                               : hash_pool[$urandom_range(7)]);
      else if (r < 88) send_op(KindLookup, PageIdW'($urandom), CountW'($urandom),
                               ($urandom_range(5) == 0) ? {$urandom, $urandom}
                               : hash_pool[$urandom_range(7)]);
      else if (r < 93) send_op(KindDefrag, PageIdW'($urandom), CountW'($urandom),
                               HashW'($urandom));
      else if (r < 96) send_op(KindW'($urandom_range(7, 6)), PageIdW'($urandom),
                               CountW'($urandom), HashW'($urandom));
      else send_op(KindFree, pid, CountW'($urandom), HashW'($urandom));
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int k = 0; k < 8; k++) hash_pool[k] = {$urandom, $urandom};
    hash_pool[0] = '1;
    hash_pool[1] = 64'h1;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes and special cases
    send_op(KindAlloc, '0, '0, '0);
    send_op(KindAlloc, '0, 7'd64, '0);
    send_op(KindAlloc, '0, 7'd65, '0);
    send_op(KindAlloc, '0, 7'd127, '0);
    send_op(KindAddRef, 11'd3, '0, '0);
    send_op(KindSetHash, 11'd3, '0, '1);
    send_op(KindSetHash, 11'd5, '0, '1);
    send_op(KindLookup, '0, '0, '1);
    send_op(KindLookup, '0, '0, '0);
    send_op(KindLookup, '0, '0, 64'h5555_aaaa_5555_aaaa);
    send_op(KindFree, 11'd5, '0, '0);
    send_op(KindLookup, '0, '0, '1);
    send_op(KindFree, 11'd2047, '0, '0);
    send_op(KindAddRef, 11'd1024, '0, '0);
    send_op(KindSetHash, 11'd1000, '0, 64'h1);
    send_op(KindSetHash, 11'd3, '0, '0);
    send_op(KindFree, 11'd3, '0, '0);
    send_op(KindFree, 11'd3, '0, '0);
    send_op(KindFree, 11'd0, '0, '0);
    send_op(3'd6, '1, '1, '1);
    send_op(3'd7, '0, '0, '0);
    send_op(KindDefrag, '0, '0, '0);
    send_op(KindAlloc, '0, 7'd2, '0);
    drain_results();

    for (int k = 0; k < 70; k++) live_pages = {live_pages, unsigned'(k)};

    // random phases with changing idle pattern
    send_idle_pct = 20; recv_idle_pct = 65;
    random_phase(127);
    drain_results();
    send_idle_pct = 65; recv_idle_pct = 20;
    random_phase(127);
    // fill up the pool to reach the no-space case
    for (int k = 0; k < 17; k++) send_op(KindAlloc, '0, 7'd64, '0);
    send_idle_pct = 0; recv_idle_pct = 0;
    random_phase(127);

    drain_results();
    repeat (2000) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
